// ===== rtl/ctse_pkg.sv =====
// Package with command codes, field indexes and calendar helpers for the clock time-set editor.
`default_nettype none
package ctse_pkg;

	// Commands carried in the input tuser.
	typedef enum logic [2:0] {
		CMD_TOGGLE = 3'd0,
		CMD_NEXT   = 3'd1,
		CMD_INC    = 3'd2,
		CMD_DEC    = 3'd3,
		CMD_LOAD   = 3'd4,
		CMD_TICK   = 3'd5
	} cmd_t;

	// Field selection codes.
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;

	localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

	// Date and time as held in the block.
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} datetime_t;

	// Days in a month; a year is leap when divisible by four and not zero.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
		logic [4:0] len;
		begin
			case (m)
				4'd2: len = ((y[1:0] == 2'b00) && (y != 7'd0)) ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/clock_time_set_editor.sv =====
// Top level of the clock time-set editor: input register, edit logic and result register.
// A request waits in the input register and enters the result register once that register is free or being drained.
// Throughput: one request per cycle while the result stream is not stalled; all edit logic sits between the registers.
// The input register holds one request while a result waits; with both full and m_axis_tready low the input stalls.
// Reset (arst_n low, asynchronous): date 00-01-01 00:00:00, display mode, year selected,
// blink phase 0, tick count 0, blink period 500, both pipeline stages empty.
`default_nettype none
module clock_time_set_editor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write: blink period in ticks.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: load_year[6:0], load_month[10:7], load_day[15:11], load_hour[20:16],
	//        load_minute[26:21], load_second[32:27], zero[39:33]
	input  wire logic [39:0] s_axis_tdata,
	// tuser: command[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: year[6:0], month[10:7], day[15:11], hour[20:16], minute[26:21],
	//        second[32:27], selected_field[35:33], setting_mode[36], blink_phase[37],
	//        write_back[38], zero[39]
	output logic [39:0]      m_axis_tdata
);
	import ctse_pkg::*;

	logic        valid_s1;
	logic [2:0]  cmd_s1;
	datetime_t   load_s1;
	logic        adv;

	datetime_t   dt_q;
	logic        mode_q;
	logic [2:0]  sel_q;
	logic        blink_q;
	logic [15:0] tick_q;
	logic [15:0] period_q;
	logic        out_valid_q;
	logic [38:0] out_q;

	datetime_t   dt_d;
	logic        mode_d;
	logic [2:0]  sel_d;
	logic        blink_d;
	logic [15:0] tick_d;
	logic        wb_d;

	// Handshakes: stage 1 moves on whenever the result register is free or being drained.
	assign cfg_ready     = 1'b1;
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1         <= s_axis_tuser;
			load_s1.year   <= s_axis_tdata[6:0];
			load_s1.month  <= s_axis_tdata[10:7];
			load_s1.day    <= s_axis_tdata[15:11];
			load_s1.hour   <= s_axis_tdata[20:16];
			load_s1.minute <= s_axis_tdata[26:21];
			load_s1.second <= s_axis_tdata[32:27];
		end
	end

	// Edit logic: next state for the request in stage 1.
	always_comb begin
		logic [6:0]  v;
		logic [6:0]  lo;
		logic [6:0]  hi;
		logic [15:0] tick_inc;
		logic [4:0]  len;
		logic        edited;

		dt_d     = dt_q;
		mode_d   = mode_q;
		sel_d    = sel_q;
		blink_d  = blink_q;
		tick_d   = tick_q;
		wb_d     = 1'b0;
		edited   = 1'b0;
		v        = 7'd0;
		lo       = 7'd0;
		hi       = 7'd59;
		tick_inc = tick_q + 16'd1;

		case (cmd_s1)
			CMD_TOGGLE: begin
				if (!mode_q) begin
					mode_d = 1'b1;
					sel_d  = FLD_YEAR;
				end else begin
					mode_d = 1'b0;
					wb_d   = 1'b1;
				end
			end
			CMD_NEXT: begin
				if (mode_q) begin
					sel_d = (sel_q >= FLD_SECOND) ? FLD_YEAR : sel_q + 3'd1;
				end
			end
			CMD_INC, CMD_DEC: begin
				if (mode_q) begin
					edited = 1'b1;
					// Current value and its range for the selected field.
					case (sel_q)
						FLD_YEAR: begin
							v  = dt_q.year;
							hi = 7'd99;
						end
						FLD_MONTH: begin
							v  = {3'd0, dt_q.month};
							lo = 7'd1;
							hi = 7'd12;
						end
						FLD_DAY: begin
							v  = {2'd0, dt_q.day};
							lo = 7'd1;
							hi = {2'd0, month_len(dt_q.month, dt_q.year)};
						end
						FLD_HOUR: begin
							v  = {2'd0, dt_q.hour};
							hi = 7'd23;
						end
						FLD_MINUTE: v = {1'b0, dt_q.minute};
						default: v = {1'b0, dt_q.second};
					endcase
					if (cmd_s1 == CMD_INC) begin
						v = (v >= hi) ? lo : v + 7'd1;
					end else begin
						v = (v <= lo) ? hi : v - 7'd1;
					end
					case (sel_q)
						FLD_YEAR:   dt_d.year   = v;
						FLD_MONTH:  dt_d.month  = v[3:0];
						FLD_DAY:    dt_d.day    = v[4:0];
						FLD_HOUR:   dt_d.hour   = v[4:0];
						FLD_MINUTE: dt_d.minute = v[5:0];
						default:    dt_d.second = v[5:0];
					endcase
				end
			end
			CMD_LOAD: begin
				if (!mode_q) begin
					edited      = 1'b1;
					dt_d.year   = (load_s1.year > 7'd99) ? 7'd0 : load_s1.year;
					dt_d.month  = (load_s1.month == 4'd0 || load_s1.month > 4'd12) ?
						4'd1 : load_s1.month;
					dt_d.day    = load_s1.day;
					dt_d.hour   = (load_s1.hour > 5'd23) ? 5'd0 : load_s1.hour;
					dt_d.minute = (load_s1.minute > 6'd59) ? 6'd0 : load_s1.minute;
					dt_d.second = (load_s1.second > 6'd59) ? 6'd0 : load_s1.second;
				end
			end
			CMD_TICK: begin
				tick_d = tick_inc;
				if (tick_inc >= period_q) begin
					tick_d  = 16'd0;
					blink_d = !blink_q;
				end
			end
			default: begin
			end
		endcase

		// Day wrap against the month length after any edit.
		len = month_len(dt_d.month, dt_d.year);
		if (edited && (dt_d.day > len || dt_d.day == 5'd0)) begin
			dt_d.day = 5'd1;
		end
	end

	// State and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q     <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
				minute: 6'd0, second: 6'd0};
			mode_q   <= 1'b0;
			sel_q    <= FLD_YEAR;
			blink_q  <= 1'b0;
			tick_q   <= 16'd0;
			period_q <= BLINK_PERIOD_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			if (valid_s1 && adv) begin
				dt_q    <= dt_d;
				mode_q  <= mode_d;
				sel_q   <= sel_d;
				blink_q <= blink_d;
				tick_q  <= tick_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_q <= {wb_d, blink_d, mode_d, sel_d, dt_d.second, dt_d.minute, dt_d.hour,
				dt_d.day, dt_d.month, dt_d.year};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

endmodule
`default_nettype wire
